@@ hdl/csia_pkg.sv @@
// Package for the checked signed integer ALU: data width, operation and status
// codes, sequencer states and derived constants. No dependencies.
`default_nettype none

package csia_pkg;

  localparam int unsigned DATA_WIDTH = 64;
  localparam int unsigned FIELD_W    = 64;
  localparam int unsigned ACC_W      = DATA_WIDTH + 2;
  localparam int unsigned CNT_W      = $clog2(DATA_WIDTH);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;
  localparam logic [2:0] OP_POW = 3'd5;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_OVF  = 3'd1;
  localparam logic [2:0] ST_DIV0 = 3'd2;
  localparam logic [2:0] ST_ZNEG = 3'd3;
  localparam logic [2:0] ST_UNK  = 3'd4;

  localparam logic [ACC_W-1:0] LIM_NEG = ACC_W'(1) << (DATA_WIDTH - 1);
  localparam logic [ACC_W-1:0] LIM_POS = LIM_NEG - ACC_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAGA,
    S_MAGB,
    S_DECODE,
    S_MUL,
    S_MULFIN,
    S_POW,
    S_DIV,
    S_DIVFIN,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

@@ hdl/csia_req_if.sv @@
// Request channel of the checked signed integer ALU: valid/ready plus opcode
// and two signed operands. Depends on csia_pkg.
`default_nettype none

interface csia_req_if
  import csia_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [2:0]                req_type;
  logic signed [FIELD_W-1:0] operand_a;
  logic signed [FIELD_W-1:0] operand_b;

  modport source (output valid, output req_type, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input req_type, input operand_a, input operand_b,
                output ready);
endinterface

`default_nettype wire

@@ hdl/csia_rsp_if.sv @@
// Response channel of the checked signed integer ALU: valid/ready plus result
// and status. Depends on csia_pkg.
`default_nettype none

interface csia_rsp_if
  import csia_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] result;
  logic [2:0]                status;

  modport source (output valid, output result, output status, input ready);
  modport sink (input valid, input result, input status, output ready);
endinterface

`default_nettype wire

@@ hdl/checked_signed_integer_alu_top.sv @@
// Top level of the checked signed integer ALU: sequencer around one shared
// adder/subtractor. Depends on csia_pkg, csia_req_if and csia_rsp_if.
`default_nettype none

// The block takes one transaction at a time and answers each with exactly one
// transaction. All arithmetic runs through a single adder/subtractor of
// DATA_WIDTH+2 bits under a small sequencer. Add, subtract, unknown operations
// and requests that need no iteration pass S_MAGA, S_MAGB and S_DECODE and then
// give a valid result in S_DONE. Multiply and divide/modulo iterate in S_MUL or
// S_DIV, one shift-add or restoring-subtract step per cycle, and finish in
// S_MULFIN or S_DIVFIN. Power runs k multiplications, where k is the exponent or
// the step at which overflow is found; k never exceeds DATA_WIDTH. The request
// side is ready only while the sequencer is idle, from the cycle after the
// response transaction, and a finished result is held until the response
// transaction completes.
module checked_signed_integer_alu_top
  import csia_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  csia_req_if.sink   req_i,
  csia_rsp_if.source rsp_o
);

  localparam int unsigned W = DATA_WIDTH;

  state_e                  state_q, state_d;
  logic [2:0]              op_q, op_d;
  logic [W-1:0]            a_q, a_d, b_q, b_d;
  logic [W-1:0]            ua_q, ua_d, ub_q, ub_d;
  logic [W-1:0]            mcand_q, mcand_d, quo_q, quo_d;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [W-1:0]            exp_q, exp_d, pmag_q, pmag_d;
  logic                    pneg_q, pneg_d, mneg_q, mneg_d, ovf_q, ovf_d;
  logic [W-1:0]            res_q, res_d;
  logic [2:0]              st_q, st_d;

  logic [ACC_W-1:0]        ux, uy, usum, lim;
  logic                    usub;
  logic                    sa, sb, as_ovf, go_mul, go_div, go_pow, a_is_m1;

  function automatic logic [ACC_W-1:0] sx(input logic [W-1:0] v);
    return ACC_W'($signed(v));
  endfunction

  assign sa      = a_q[W-1];
  assign sb      = b_q[W-1];
  assign a_is_m1 = (a_q == '1);
  assign usum    = ux + (usub ? ~uy : uy) + ACC_W'(usub);
  assign lim     = mneg_q ? LIM_NEG : LIM_POS;

  assign as_ovf = (op_q == OP_ADD) ? ((sa == sb) && (usum[W-1] != sa))
                                   : ((sa != sb) && (usum[W-1] != sa));
  assign go_mul = (op_q == OP_MUL) && (ua_q != '0) && (ub_q != '0);
  assign go_div = ((op_q == OP_DIV) || (op_q == OP_MOD)) && (ub_q != '0);
  assign go_pow = (op_q == OP_POW) && (a_q != '0) && (a_q != W'(1)) && !a_is_m1
                  && !sb && (b_q != '0);

  // Shared unit operand selection.
  always_comb begin
    ux   = '0;
    uy   = '0;
    usub = 1'b0;
    case (state_q)
      S_MAGA: begin
        uy   = sx(a_q);
        usub = 1'b1;
      end
      S_MAGB: begin
        uy   = sx(b_q);
        usub = 1'b1;
      end
      S_DECODE: begin
        ux   = sx(a_q);
        uy   = sx(b_q);
        usub = (op_q == OP_SUB);
      end
      S_MUL: begin
        ux = acc_q << 1;
        uy = quo_q[W-1] ? ACC_W'(mcand_q) : '0;
      end
      S_MULFIN: begin
        uy   = ACC_W'(acc_q[W-1:0]);
        usub = 1'b1;
      end
      S_POW: begin
        if (exp_q == '0) begin
          uy = ACC_W'(pmag_q);
        end else begin
          ux = ACC_W'(exp_q);
          uy = ACC_W'(1);
        end
        usub = 1'b1;
      end
      S_DIV: begin
        ux   = ACC_W'({acc_q[W-1:0], quo_q[W-1]});
        uy   = ACC_W'(ub_q);
        usub = 1'b1;
      end
      S_DIVFIN: begin
        if (op_q == OP_MOD) begin
          ux = ACC_W'(ub_q);
          uy = ACC_W'(acc_q[W-1:0]);
        end else begin
          uy = ACC_W'(quo_q);
        end
        usub = 1'b1;
      end
      default: begin
        usub = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) state_d = S_MAGA;
      end
      S_MAGA:   state_d = S_MAGB;
      S_MAGB:   state_d = S_DECODE;
      S_DECODE: begin
        if (go_mul || go_pow) begin
          state_d = go_mul ? S_MUL : S_POW;
        end else if (go_div) begin
          state_d = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MUL: begin
        if (cnt_q == '0) state_d = S_MULFIN;
      end
      S_MULFIN: begin
        state_d = ((op_q == OP_POW) && !ovf_q) ? S_POW : S_DONE;
      end
      S_POW: begin
        state_d = (exp_q == '0) ? S_DONE : S_MUL;
      end
      S_DIV: begin
        if (cnt_q == '0) state_d = S_DIVFIN;
      end
      S_DIVFIN: state_d = S_DONE;
      S_DONE: begin
        if (rsp_o.ready) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    op_d    = op_q;
    a_d     = a_q;
    b_d     = b_q;
    ua_d    = ua_q;
    ub_d    = ub_q;
    mcand_d = mcand_q;
    quo_d   = quo_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    exp_d   = exp_q;
    pmag_d  = pmag_q;
    pneg_d  = pneg_q;
    mneg_d  = mneg_q;
    ovf_d   = ovf_q;
    res_d   = res_q;
    st_d    = st_q;
    case (state_q)
      S_IDLE: begin
        op_d = req_i.req_type;
        a_d  = req_i.operand_a[W-1:0];
        b_d  = req_i.operand_b[W-1:0];
      end
      S_MAGA: ua_d = sa ? usum[W-1:0] : a_q;
      S_MAGB: ub_d = sb ? usum[W-1:0] : b_q;
      S_DECODE: begin
        res_d   = '0;
        st_d    = ST_OK;
        acc_d   = '0;
        ovf_d   = 1'b0;
        cnt_d   = CNT_W'(W - 1);
        mcand_d = ua_q;
        quo_d   = (op_q == OP_MUL) ? ub_q : ua_q;
        mneg_d  = sa ^ sb;
        pmag_d  = W'(1);
        pneg_d  = 1'b0;
        exp_d   = b_q;
        case (op_q)
          OP_ADD, OP_SUB: begin
            st_d  = as_ovf ? ST_OVF : ST_OK;
            res_d = as_ovf ? '0 : usum[W-1:0];
          end
          OP_MUL: begin
            st_d = ST_OK;
          end
          OP_DIV, OP_MOD: begin
            st_d = (ub_q == '0) ? ST_DIV0 : ST_OK;
          end
          OP_POW: begin
            if (a_q == '0) begin
              st_d = sb ? ST_ZNEG : ST_OK;
            end else if (a_q == W'(1)) begin
              res_d = W'(1);
            end else if (a_is_m1) begin
              res_d = b_q[0] ? '1 : W'(1);
            end else if (!sb && (b_q == '0)) begin
              res_d = W'(1);
            end
          end
          default: begin
            st_d = ST_UNK;
          end
        endcase
      end
      S_MUL: begin
        acc_d = usum;
        if (usum > lim) ovf_d = 1'b1;
        quo_d = quo_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
      end
      S_MULFIN: begin
        if (ovf_q) begin
          res_d = '0;
          st_d  = ST_OVF;
        end else if (op_q == OP_POW) begin
          pmag_d = acc_q[W-1:0];
          pneg_d = mneg_q;
        end else begin
          res_d = mneg_q ? usum[W-1:0] : acc_q[W-1:0];
          st_d  = ST_OK;
        end
      end
      S_POW: begin
        if (exp_q == '0) begin
          res_d = pneg_q ? usum[W-1:0] : pmag_q;
          st_d  = ST_OK;
        end else begin
          exp_d   = usum[W-1:0];
          mcand_d = ua_q;
          quo_d   = pmag_q;
          acc_d   = '0;
          ovf_d   = 1'b0;
          mneg_d  = pneg_q ^ sa;
          cnt_d   = CNT_W'(W - 1);
        end
      end
      S_DIV: begin
        acc_d = usum[ACC_W-1] ? ux : usum;
        quo_d = {quo_q[W-2:0], ~usum[ACC_W-1]};
        cnt_d = cnt_q - CNT_W'(1);
      end
      S_DIVFIN: begin
        st_d = ST_OK;
        if (op_q == OP_MOD) begin
          res_d = (sa && (acc_q[W-1:0] != '0)) ? usum[W-1:0] : acc_q[W-1:0];
        end else if (!(sa ^ sb) && quo_q[W-1]) begin
          res_d = '0;
          st_d  = ST_OVF;
        end else begin
          res_d = (sa ^ sb) ? usum[W-1:0] : quo_q;
        end
      end
      default: begin
        st_d = st_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    a_q     <= a_d;
    b_q     <= b_d;
    ua_q    <= ua_d;
    ub_q    <= ub_d;
    mcand_q <= mcand_d;
    quo_q   <= quo_d;
    acc_q   <= acc_d;
    cnt_q   <= cnt_d;
    exp_q   <= exp_d;
    pmag_q  <= pmag_d;
    pneg_q  <= pneg_d;
    mneg_q  <= mneg_d;
    ovf_q   <= ovf_d;
    res_q   <= res_d;
    st_q    <= st_d;
  end

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = (state_q == S_DONE);
  assign rsp_o.result = FIELD_W'($signed(res_q));
  assign rsp_o.status = st_q;

  // An erroneous result always reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ST_OK)) |-> (rsp_o.result == '0))
    else $error("nonzero result with error status");

  // Request and response sides are never open at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid))
    else $error("request ready while a response is pending");

  // An accepted transaction closes the request side on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request side still open after a transaction");

  // A completed response returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.ready) |=> (req_i.ready && !rsp_o.valid))
    else $error("sequencer did not return to idle");

endmodule

`default_nettype wire
